@@ rtl/text_mode_video_console_assert.svh @@
// Assertion macros shared by the console RTL.
// Depends on a clock named clock and a reset named reset in the including scope.
`ifndef TEXT_MODE_VIDEO_CONSOLE_ASSERT_SVH
`define TEXT_MODE_VIDEO_CONSOLE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define TMVC_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("console check failed");

// Check that cons holds in the cycle after ante.
`define TMVC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("console check failed");

`endif

@@ rtl/tmvc_pkg.sv @@
// Shared types, command codes and constants for the text console engine.
// No dependencies.
`timescale 1ns / 1ps

package tmvc_pkg;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;
   localparam int DEF_PAGES   = 8;

   localparam logic [7:0]  SPACE_CHAR  = 8'h20;
   localparam logic [7:0]  BLANK_ATTR  = 8'h07;
   localparam logic [7:0]  CH_BEL      = 8'h07;
   localparam logic [7:0]  CH_BS       = 8'h08;
   localparam logic [7:0]  CH_LF       = 8'h0A;
   localparam logic [7:0]  CH_CR       = 8'h0D;
   localparam logic [15:0] RESET_SHAPE = 16'h0607;
   localparam logic [6:0]  RESET_MODE  = 7'd3;

   typedef enum logic [3:0] {
      CMD_SETMODE   = 4'd0,
      CMD_GETMODE   = 4'd1,
      CMD_SETSHAPE  = 4'd2,
      CMD_SETPOS    = 4'd3,
      CMD_GETPOS    = 4'd4,
      CMD_SETPAGE   = 4'd5,
      CMD_SCROLLUP  = 4'd6,
      CMD_SCROLLDN  = 4'd7,
      CMD_READCELL  = 4'd8,
      CMD_WRCHATTR  = 4'd9,
      CMD_WRCHAR    = 4'd10,
      CMD_TELETYPE  = 4'd11
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SC_CELL,
      ST_SC_WR,
      ST_RC_RD,
      ST_RC_CAP,
      ST_WR_STEP,
      ST_WR_WR,
      ST_TT_CTL,
      ST_TT_WR,
      ST_TT_FIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [3:0]  cmd;
      logic [7:0]  byte_arg;
      logic [7:0]  attr;
      logic [7:0]  page_sel;
      logic [7:0]  row_a;
      logic [7:0]  col_a;
      logic [7:0]  row_b;
      logic [7:0]  col_b;
      logic [15:0] repeat_count;
      logic [15:0] shape_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  char_read;
      logic [7:0]  attr_read;
      logic [7:0]  cursor_col;
      logic [7:0]  cursor_row;
      logic [15:0] cursor_shape;
      logic [6:0]  video_mode;
      logic [2:0]  active_page;
   } rsp_type;

   // Cell memory access issued by the sequencer.
   typedef struct packed {
      logic        we;
      logic        re;
      logic [15:0] wdata;
   } cell_op_type;

endpackage

@@ rtl/tmvc_addr_unit.sv @@
// Shared address unit: maps a row/column pair to a linear cell address
// and flags whether it lies inside the grid. Depends on nothing.
`timescale 1ns / 1ps

module tmvc_addr_unit #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   parameter int AW      = 11
) (
   input  logic [7:0]    row,
   input  logic [7:0]    col,
   output logic [AW-1:0] addr,
   output logic          in_grid
);

   logic [15:0] prod;

   assign prod    = 16'(row) * 16'(COLUMNS);
   assign addr    = AW'(prod + 16'(col));
   assign in_grid = ({1'b0, row} < 9'(ROWS)) && ({1'b0, col} < 9'(COLUMNS));

endmodule

@@ rtl/tmvc_cell_ram.sv @@
// Single-port cell store with registered read data.
// Depends on tmvc_pkg for the access struct.
`timescale 1ns / 1ps

module tmvc_cell_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic                 clock,
   input  tmvc_pkg::cell_op_type op,
   input  logic [AW-1:0]        addr,
   output logic [15:0]          rdata
);

   logic [15:0] cell_mem [DEPTH];
   logic [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (op.we) begin
         cell_mem[addr] <= op.wdata;
      end
      if (op.re) begin
         rdata_ff <= cell_mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/text_mode_video_console.sv @@
// Text console engine top level: command sequencer, cursors and result register.
// Depends on tmvc_pkg, tmvc_addr_unit, tmvc_cell_ram and the assertion header.
`timescale 1ns / 1ps

// One command is taken at a time; req_stall stays high until its result is
// registered. Register-only commands (get/set mode without clear, shape,
// position, page, get position) need no cell access. Read cell reads the
// cell under the cursor, then captures it. Scrolls walk the clamped window
// cell by cell through the single memory port: 1 blanked cell per cycle, and
// each copied cell read, then written. Set mode with clear and the teletype
// full-screen scroll walk all ROWS*COLUMNS cells. Repeated writes store 1
// character per cycle with attribute; without, each cell is read, then written.
// After reset the engine blanks the whole cell store before it takes the first
// command. Every cell address comes from one shared row*COLUMNS+col unit.
module text_mode_video_console #(
   parameter int COLUMNS = tmvc_pkg::DEF_COLUMNS,
   parameter int ROWS    = tmvc_pkg::DEF_ROWS,
   parameter int PAGES   = tmvc_pkg::DEF_PAGES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tmvc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tmvc_pkg::rsp_type rsp_payload
);

`include "text_mode_video_console_assert.svh"

   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam logic [7:0] LAST_ROW = 8'(ROWS - 1);
   localparam logic [7:0] LAST_COL = 8'(COLUMNS - 1);
   localparam logic [15:0] BLANK_CELL = {tmvc_pkg::BLANK_ATTR, tmvc_pkg::SPACE_CHAR};

   // Fold a page number above the last page onto page 0.
   function automatic logic [PW-1:0] page_index(input logic [7:0] p);
      logic [PW-1:0] r;
      r = '0;
      if ({1'b0, p} <= 9'(PAGES - 1)) begin
         r = PW'(p);
      end
      return r;
   endfunction

   tmvc_pkg::state_type state_ff, state_in;

   // Request fields held for the life of the transaction.
   logic [PW-1:0] pg_ff, pg_in;
   logic          wr_attr_ff, wr_attr_in;
   logic [7:0]    ch_ff, ch_in;
   logic [7:0]    at_ff, at_in;
   logic [15:0]   cnt_ff, cnt_in;
   logic [7:0]    wr_row_ff, wr_row_in;
   logic [7:0]    wr_col_ff, wr_col_in;
   logic [15:0]   rd_val_ff, rd_val_in;
   logic          rd_ok_ff, rd_ok_in;

   // Window walker.
   logic          sc_up_ff, sc_up_in;
   logic          sc_clr_ff, sc_clr_in;
   logic          sc_quiet_ff, sc_quiet_in;
   logic [7:0]    sc_lines_ff, sc_lines_in;
   logic [7:0]    sc_r1_ff, sc_r1_in;
   logic [7:0]    sc_c1_ff, sc_c1_in;
   logic [7:0]    sc_r2_ff, sc_r2_in;
   logic [7:0]    sc_c2_ff, sc_c2_in;
   logic [7:0]    sc_row_ff, sc_row_in;
   logic [7:0]    sc_col_ff, sc_col_in;
   logic [15:0]   sc_fill_ff, sc_fill_in;

   // Architectural state.
   logic [6:0]    mode_ff, mode_in;
   logic [PW-1:0] page_ff, page_in;
   logic [15:0]   shape_ff, shape_in;
   logic [7:0]    cur_row_ff [PAGES];
   logic [7:0]    cur_row_in [PAGES];
   logic [7:0]    cur_col_ff [PAGES];
   logic [7:0]    cur_col_in [PAGES];

   tmvc_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Shared address unit and memory port.
   logic [7:0]            addr_row, addr_col;
   logic [AW-1:0]         cell_addr;
   logic                  cell_in_grid;
   tmvc_pkg::cell_op_type cell_op;
   logic [15:0]           cell_rdata;

   tmvc_addr_unit #(.COLUMNS(COLUMNS), .ROWS(ROWS), .AW(AW)) u_addr (
      .row     (addr_row),
      .col     (addr_col),
      .addr    (cell_addr),
      .in_grid (cell_in_grid)
   );

   tmvc_cell_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
      .clock (clock),
      .op    (cell_op),
      .addr  (cell_addr),
      .rdata (cell_rdata)
   );

   // Walker helpers: source row, copy-or-blank choice, end of window.
   logic [7:0] sc_src_row;
   logic       sc_copy, sc_last_col, sc_last_row, sc_done;

   always_comb begin
      sc_src_row  = sc_up_ff ? 8'(sc_row_ff + sc_lines_ff) : 8'(sc_row_ff - sc_lines_ff);
      sc_copy     = !sc_clr_ff &&
                    (sc_up_ff ? ((9'(sc_row_ff) + 9'(sc_lines_ff)) <= 9'(sc_r2_ff))
                              : (9'(sc_row_ff) >= (9'(sc_r1_ff) + 9'(sc_lines_ff))));
      sc_last_col = (sc_col_ff == sc_c2_ff);
      sc_last_row = sc_up_ff ? (sc_row_ff == sc_r2_ff) : (sc_row_ff == sc_r1_ff);
      sc_done     = sc_last_col && sc_last_row;
   end

   // Repeated-write cursor advance.
   logic [7:0] wr_nc, wr_nr_raw, wr_nr;
   logic       wr_wrap;

   always_comb begin
      wr_nc     = 8'(wr_col_ff + 8'd1);
      wr_wrap   = ({1'b0, wr_nc} >= 9'(COLUMNS));
      wr_nr_raw = wr_wrap ? 8'(wr_row_ff + 8'd1) : wr_row_ff;
      wr_nr     = ({1'b0, wr_nr_raw} >= 9'(ROWS)) ? LAST_ROW : wr_nr_raw;
   end

   // Teletype cursor of the selected page.
   logic [7:0] tt_row, tt_col, tt_nc, tt_attr;
   logic       tt_wrap;

   always_comb begin
      tt_row  = cur_row_ff[pg_ff];
      tt_col  = cur_col_ff[pg_ff];
      tt_nc   = 8'(tt_col + 8'd1);
      tt_wrap = ({1'b0, tt_nc} >= 9'(COLUMNS));
      tt_attr = (cell_rdata[15:8] == 8'd0) ? tmvc_pkg::BLANK_ATTR : cell_rdata[15:8];
   end

   // Scroll window clamp for a new request.
   logic [7:0] req_r2, req_c2;
   logic [8:0] req_height;

   always_comb begin
      req_r2     = (req_payload.row_b > LAST_ROW) ? LAST_ROW : req_payload.row_b;
      req_c2     = (req_payload.col_b > LAST_COL) ? LAST_COL : req_payload.col_b;
      req_height = 9'(req_r2) - 9'(req_payload.row_a) + 9'd1;
   end

   always_comb begin
      state_in     = state_ff;
      pg_in        = pg_ff;
      wr_attr_in   = wr_attr_ff;
      ch_in        = ch_ff;
      at_in        = at_ff;
      cnt_in       = cnt_ff;
      wr_row_in    = wr_row_ff;
      wr_col_in    = wr_col_ff;
      rd_val_in    = rd_val_ff;
      rd_ok_in     = rd_ok_ff;
      sc_up_in     = sc_up_ff;
      sc_clr_in    = sc_clr_ff;
      sc_quiet_in  = sc_quiet_ff;
      sc_lines_in  = sc_lines_ff;
      sc_r1_in     = sc_r1_ff;
      sc_c1_in     = sc_c1_ff;
      sc_r2_in     = sc_r2_ff;
      sc_c2_in     = sc_c2_ff;
      sc_row_in    = sc_row_ff;
      sc_col_in    = sc_col_ff;
      sc_fill_in   = sc_fill_ff;
      mode_in      = mode_ff;
      page_in      = page_ff;
      shape_in     = shape_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      addr_row     = sc_row_ff;
      addr_col     = sc_col_ff;
      cell_op      = '0;

      unique case (state_ff)
         tmvc_pkg::ST_IDLE: begin
            if (req_valid) begin
               pg_in     = page_index(req_payload.page_sel);
               ch_in     = req_payload.byte_arg;
               at_in     = req_payload.attr;
               rd_val_in = '0;
               state_in  = tmvc_pkg::ST_DONE;
               unique case (tmvc_pkg::cmd_type'(req_payload.cmd))
                  tmvc_pkg::CMD_SETMODE: begin
                     mode_in = req_payload.byte_arg[6:0];
                     page_in = '0;
                     for (int i = 0; i < PAGES; i++) begin
                        cur_row_in[i] = '0;
                        cur_col_in[i] = '0;
                     end
                     // Bit 7 keeps the screen contents.
                     if (!req_payload.byte_arg[7]) begin
                        sc_up_in    = 1'b1;
                        sc_clr_in   = 1'b1;
                        sc_quiet_in = 1'b0;
                        sc_lines_in = '0;
                        sc_r1_in    = '0;
                        sc_c1_in    = '0;
                        sc_r2_in    = LAST_ROW;
                        sc_c2_in    = LAST_COL;
                        sc_row_in   = '0;
                        sc_col_in   = '0;
                        sc_fill_in  = BLANK_CELL;
                        state_in    = tmvc_pkg::ST_SC_CELL;
                     end
                  end
                  tmvc_pkg::CMD_SETSHAPE: begin
                     shape_in = req_payload.shape_value;
                  end
                  tmvc_pkg::CMD_SETPOS: begin
                     cur_row_in[page_index(req_payload.page_sel)] = req_payload.row_a;
                     cur_col_in[page_index(req_payload.page_sel)] = req_payload.col_a;
                  end
                  tmvc_pkg::CMD_SETPAGE: begin
                     page_in = page_index(req_payload.byte_arg);
                  end
                  tmvc_pkg::CMD_SCROLLUP, tmvc_pkg::CMD_SCROLLDN: begin
                     // An empty window leaves the screen alone.
                     if ((req_payload.row_a <= req_r2) && (req_payload.col_a <= req_c2)) begin
                        sc_up_in    = (req_payload.cmd == tmvc_pkg::CMD_SCROLLUP);
                        sc_clr_in   = (req_payload.byte_arg == 8'd0) ||
                                      (9'(req_payload.byte_arg) > req_height);
                        sc_quiet_in = 1'b0;
                        sc_lines_in = req_payload.byte_arg;
                        sc_r1_in    = req_payload.row_a;
                        sc_c1_in    = req_payload.col_a;
                        sc_r2_in    = req_r2;
                        sc_c2_in    = req_c2;
                        sc_row_in   = (req_payload.cmd == tmvc_pkg::CMD_SCROLLUP) ?
                                      req_payload.row_a : req_r2;
                        sc_col_in   = req_payload.col_a;
                        sc_fill_in  = {req_payload.attr, tmvc_pkg::SPACE_CHAR};
                        state_in    = tmvc_pkg::ST_SC_CELL;
                     end
                  end
                  tmvc_pkg::CMD_READCELL: begin
                     state_in = tmvc_pkg::ST_RC_RD;
                  end
                  tmvc_pkg::CMD_WRCHATTR, tmvc_pkg::CMD_WRCHAR: begin
                     wr_attr_in = (req_payload.cmd == tmvc_pkg::CMD_WRCHATTR);
                     cnt_in     = req_payload.repeat_count;
                     wr_row_in  = cur_row_ff[0];
                     wr_col_in  = cur_col_ff[0];
                     if (req_payload.repeat_count != 16'd0) begin
                        state_in = tmvc_pkg::ST_WR_STEP;
                     end
                  end
                  tmvc_pkg::CMD_TELETYPE: begin
                     state_in = tmvc_pkg::ST_TT_CTL;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Decide copy or blank for the current cell; blanks go out now.
         tmvc_pkg::ST_SC_CELL: begin
            if (sc_copy) begin
               addr_row   = sc_src_row;
               cell_op.re = 1'b1;
               state_in   = tmvc_pkg::ST_SC_WR;
            end else begin
               cell_op.we    = 1'b1;
               cell_op.wdata = sc_fill_ff;
            end
            if (!sc_copy || state_ff == tmvc_pkg::ST_SC_WR) begin
               if (sc_last_col) begin
                  sc_col_in = sc_c1_ff;
                  sc_row_in = sc_up_ff ? 8'(sc_row_ff + 8'd1) : 8'(sc_row_ff - 8'd1);
               end else begin
                  sc_col_in = 8'(sc_col_ff + 8'd1);
               end
               if (sc_done) begin
                  state_in = sc_quiet_ff ? tmvc_pkg::ST_IDLE : tmvc_pkg::ST_DONE;
               end
            end
         end

         // Land the copied cell and advance.
         tmvc_pkg::ST_SC_WR: begin
            cell_op.we    = 1'b1;
            cell_op.wdata = cell_rdata;
            state_in      = tmvc_pkg::ST_SC_CELL;
            if (sc_last_col) begin
               sc_col_in = sc_c1_ff;
               sc_row_in = sc_up_ff ? 8'(sc_row_ff + 8'd1) : 8'(sc_row_ff - 8'd1);
            end else begin
               sc_col_in = 8'(sc_col_ff + 8'd1);
            end
            if (sc_done) begin
               state_in = sc_quiet_ff ? tmvc_pkg::ST_IDLE : tmvc_pkg::ST_DONE;
            end
         end

         tmvc_pkg::ST_RC_RD: begin
            addr_row   = tt_row;
            addr_col   = tt_col;
            rd_ok_in   = cell_in_grid;
            cell_op.re = cell_in_grid;
            state_in   = tmvc_pkg::ST_RC_CAP;
         end

         tmvc_pkg::ST_RC_CAP: begin
            rd_val_in = rd_ok_ff ? cell_rdata : 16'd0;
            state_in  = tmvc_pkg::ST_DONE;
         end

         tmvc_pkg::ST_WR_STEP: begin
            addr_row = wr_row_ff;
            addr_col = wr_col_ff;
            if (wr_attr_ff) begin
               cell_op.we    = cell_in_grid;
               cell_op.wdata = {at_ff, ch_ff};
               cnt_in        = 16'(cnt_ff - 16'd1);
               wr_row_in     = wr_nr;
               wr_col_in     = wr_wrap ? 8'd0 : wr_nc;
               if (cnt_ff == 16'd1) begin
                  state_in = tmvc_pkg::ST_DONE;
               end
            end else begin
               cell_op.re = cell_in_grid;
               state_in   = tmvc_pkg::ST_WR_WR;
            end
         end

         // Keep the old attribute, replace the character.
         tmvc_pkg::ST_WR_WR: begin
            addr_row      = wr_row_ff;
            addr_col      = wr_col_ff;
            cell_op.we    = cell_in_grid;
            cell_op.wdata = {cell_rdata[15:8], ch_ff};
            cnt_in        = 16'(cnt_ff - 16'd1);
            wr_row_in     = wr_nr;
            wr_col_in     = wr_wrap ? 8'd0 : wr_nc;
            state_in      = (cnt_ff == 16'd1) ? tmvc_pkg::ST_DONE : tmvc_pkg::ST_WR_STEP;
         end

         tmvc_pkg::ST_TT_CTL: begin
            addr_row = tt_row;
            addr_col = tt_col;
            state_in = tmvc_pkg::ST_TT_FIN;
            case (ch_ff)
               tmvc_pkg::CH_BEL: begin
               end
               tmvc_pkg::CH_BS: begin
                  if (tt_col != 8'd0) begin
                     cur_col_in[pg_ff] = 8'(tt_col - 8'd1);
                  end
               end
               tmvc_pkg::CH_LF: begin
                  cur_row_in[pg_ff] = 8'(tt_row + 8'd1);
               end
               tmvc_pkg::CH_CR: begin
                  cur_col_in[pg_ff] = 8'd0;
               end
               default: begin
                  cell_op.re = cell_in_grid;
                  state_in   = tmvc_pkg::ST_TT_WR;
               end
            endcase
         end

         tmvc_pkg::ST_TT_WR: begin
            addr_row          = tt_row;
            addr_col          = tt_col;
            cell_op.we        = cell_in_grid;
            cell_op.wdata     = {tt_attr, ch_ff};
            cur_col_in[pg_ff] = tt_wrap ? 8'd0 : tt_nc;
            cur_row_in[pg_ff] = tt_wrap ? 8'(tt_row + 8'd1) : tt_row;
            state_in          = tmvc_pkg::ST_TT_FIN;
         end

         // Past the bottom: scroll the whole screen up one line.
         tmvc_pkg::ST_TT_FIN: begin
            state_in = tmvc_pkg::ST_DONE;
            if ({1'b0, tt_row} >= 9'(ROWS)) begin
               cur_row_in[pg_ff] = LAST_ROW;
               sc_up_in    = 1'b1;
               sc_clr_in   = 1'b0;
               sc_quiet_in = 1'b0;
               sc_lines_in = 8'd1;
               sc_r1_in    = '0;
               sc_c1_in    = '0;
               sc_r2_in    = LAST_ROW;
               sc_c2_in    = LAST_COL;
               sc_row_in   = '0;
               sc_col_in   = '0;
               sc_fill_in  = BLANK_CELL;
               state_in    = tmvc_pkg::ST_SC_CELL;
            end
         end

         // Hold until the result register is free.
         tmvc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.char_read    = rd_val_ff[7:0];
               rsp_in.attr_read    = rd_val_ff[15:8];
               rsp_in.cursor_col   = cur_col_ff[pg_ff];
               rsp_in.cursor_row   = cur_row_ff[pg_ff];
               rsp_in.cursor_shape = shape_ff;
               rsp_in.video_mode   = mode_ff;
               rsp_in.active_page  = 3'(page_ff);
               rsp_valid_in        = 1'b1;
               state_in            = tmvc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tmvc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // Come out of reset blanking the whole store, with no result.
         state_ff     <= tmvc_pkg::ST_SC_CELL;
         sc_up_ff     <= 1'b1;
         sc_clr_ff    <= 1'b1;
         sc_quiet_ff  <= 1'b1;
         sc_lines_ff  <= '0;
         sc_r1_ff     <= '0;
         sc_c1_ff     <= '0;
         sc_r2_ff     <= LAST_ROW;
         sc_c2_ff     <= LAST_COL;
         sc_row_ff    <= '0;
         sc_col_ff    <= '0;
         sc_fill_ff   <= BLANK_CELL;
         mode_ff      <= tmvc_pkg::RESET_MODE;
         page_ff      <= '0;
         shape_ff     <= tmvc_pkg::RESET_SHAPE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PAGES; i++) begin
            cur_row_ff[i] <= '0;
            cur_col_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         sc_up_ff     <= sc_up_in;
         sc_clr_ff    <= sc_clr_in;
         sc_quiet_ff  <= sc_quiet_in;
         sc_lines_ff  <= sc_lines_in;
         sc_r1_ff     <= sc_r1_in;
         sc_c1_ff     <= sc_c1_in;
         sc_r2_ff     <= sc_r2_in;
         sc_c2_ff     <= sc_c2_in;
         sc_row_ff    <= sc_row_in;
         sc_col_ff    <= sc_col_in;
         sc_fill_ff   <= sc_fill_in;
         mode_ff      <= mode_in;
         page_ff      <= page_in;
         shape_ff     <= shape_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
      end
   end

   always_ff @(posedge clock) begin
      pg_ff      <= pg_in;
      wr_attr_ff <= wr_attr_in;
      ch_ff      <= ch_in;
      at_ff      <= at_in;
      cnt_ff     <= cnt_in;
      wr_row_ff  <= wr_row_in;
      wr_col_ff  <= wr_col_in;
      rd_val_ff  <= rd_val_in;
      rd_ok_ff   <= rd_ok_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall   = (state_ff != tmvc_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `TMVC_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall, state_ff != tmvc_pkg::ST_IDLE)
   `TMVC_ASSERT_SAME(a_write_in_grid, cell_op.we, cell_in_grid)
   `TMVC_ASSERT_SAME(a_one_port_op, 1'b1, !(cell_op.we && cell_op.re))
   `TMVC_ASSERT_SAME(a_rsp_taken, $fell(rsp_valid_ff), $past(!rsp_stall))

endmodule
